>>> src/brm8k_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the banked 8 KiB ROM mapper
// no dependencies; imported by every module of the block but brm8k_ram

package brm8k_pkg;

  // default ROM store depth in bytes
  localparam int unsigned ROM_BYTES_DEF = 262144;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 18;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned SIZE_W  = 19;
  localparam int unsigned BUS_W   = 16;

  // mapped address: 8-bit bank number above a 13-bit window offset
  localparam int unsigned OFF_W   = 13;
  localparam int unsigned MAP_W   = DATA_W + OFF_W;

  // bank register file
  localparam int unsigned BANK_NUM = 4;
  localparam int unsigned BANK_IW  = 2;

  // bus address map
  localparam logic [BUS_W-1:0] WIN_BASE = 16'h4000;
  localparam logic [BUS_W-1:0] WIN_END  = 16'hC000;
  localparam logic [BUS_W-1:0] REG_BASE = 16'h6000;
  localparam logic [BUS_W-1:0] REG_END  = 16'h8000;

  // value returned for reads outside the ROM
  localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_e;

  // request from the mapper to the ROM store and read pipeline
  typedef struct packed {
    logic             ram_we;
    logic             ram_re;
    logic [MAP_W-1:0] addr;
    logic             in_range;
  } map_req_t;

endpackage

>>> src/brm8k_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port RAM with registered read and read enable
// no dependencies

module brm8k_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/brm8k_map.sv
`timescale 1ns / 1ps
// bank registers and bus address mapping for the 8 KiB window mapper
// depends on brm8k_pkg

module brm8k_map #(
  parameter int unsigned ROM_BYTES = brm8k_pkg::ROM_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           take_i,
  input  logic [brm8k_pkg::OP_W-1:0]     opcode_i,
  input  logic [brm8k_pkg::ADDR_W-1:0]   address_i,
  input  logic [brm8k_pkg::DATA_W-1:0]   write_data_i,
  input  logic [brm8k_pkg::SIZE_W-1:0]   rom_size_i,
  output brm8k_pkg::map_req_t            req_o
);
  import brm8k_pkg::*;

  // one extra bit so that the store depth itself fits in the compare
  localparam int unsigned CMP_W = MAP_W + 1;
  localparam logic [CMP_W-1:0] ROM_LIMIT = CMP_W'(ROM_BYTES);

  logic [DATA_W-1:0]  bank_q [BANK_NUM];
  logic [BUS_W-1:0]   bus;
  logic [BUS_W-1:0]   rel;
  logic [BANK_IW-1:0] win;
  logic [BANK_IW-1:0] reg_sel;
  logic               in_win;
  logic               in_reg;
  logic [MAP_W-1:0]   mapped;
  logic [MAP_W-1:0]   load_addr;
  logic               load_ok;
  logic               map_ok;
  logic               bank_we;

  assign bus     = address_i[BUS_W-1:0];
  assign rel     = bus - WIN_BASE;
  assign win     = rel[OFF_W+BANK_IW-1:OFF_W];
  assign reg_sel = bus[OFF_W-1:OFF_W-BANK_IW];
  assign in_win  = (bus >= WIN_BASE) && (bus < WIN_END);
  assign in_reg  = (bus >= REG_BASE) && (bus < REG_END);

  // window reads go to bank times 8 KiB plus offset, others pass through
  always_comb begin
    if (in_win) begin
      mapped = {bank_q[win], bus[OFF_W-1:0]};
    end else begin
      mapped = MAP_W'(bus);
    end
  end

  assign load_addr = MAP_W'(address_i);
  assign load_ok   = {1'b0, load_addr} < ROM_LIMIT;
  assign map_ok    = ({1'b0, mapped} < ROM_LIMIT) &&
                     ({1'b0, mapped} < CMP_W'(rom_size_i));

  // decode the operation into store and bank register actions
  always_comb begin
    req_o   = '0;
    bank_we = 1'b0;
    case (opcode_e'(opcode_i))
      OP_LOAD: begin
        req_o.ram_we = take_i && load_ok;
        req_o.addr   = load_addr;
      end
      OP_READ: begin
        req_o.ram_re   = take_i;
        req_o.addr     = mapped;
        req_o.in_range = map_ok;
      end
      OP_WRITE: begin
        bank_we = take_i && in_reg;
      end
      default: begin
        req_o = '0;
      end
    endcase
  end

  // bank registers, reset to identity banks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BANK_NUM; i++) begin
        bank_q[i] <= DATA_W'(i);
      end
    end else if (bank_we) begin
      bank_q[reg_sel] <= write_data_i;
    end
  end

endmodule

>>> src/banked_rom_mapper_8k_unit.sv
`timescale 1ns / 1ps
// top level of the banked 8 KiB ROM mapper: handshake, read pipeline, output register
// depends on brm8k_pkg, brm8k_map and brm8k_ram
//
//   channel  | signals                                         | direction
//   ---------+-------------------------------------------------+----------
//   in       | in_valid_i, in_ready_o, opcode_i, address_i,    | in
//            | write_data_i                                    |
//   out      | out_valid_o, out_ready_i, read_data_o           | out
//   cfg      | cfg_we_i, cfg_wdata_i (rom_size)                | in
//
// one item is taken per cycle while in_ready_o is high; a bus read's byte passes
// through the ROM store read port register and then the output register
// loads and bank writes finish in the transfer cycle and give no result
// reset clears the bank registers to banks 0..3 and rom_size to 0; the store is not cleared
// a stalled output holds its byte; one more read may then wait in the store read
// stage, after which in_ready_o drops until the output is taken

module banked_rom_mapper_8k_unit #(
  parameter int unsigned ROM_BYTES = brm8k_pkg::ROM_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [brm8k_pkg::OP_W-1:0]     opcode_i,
  input  logic [brm8k_pkg::ADDR_W-1:0]   address_i,
  input  logic [brm8k_pkg::DATA_W-1:0]   write_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [brm8k_pkg::DATA_W-1:0]   read_data_o,
  input  logic                           cfg_we_i,
  input  logic [brm8k_pkg::SIZE_W-1:0]   cfg_wdata_i
);
  import brm8k_pkg::*;

  localparam int unsigned AW = (ROM_BYTES > 1) ? $clog2(ROM_BYTES) : 1;

  logic [SIZE_W-1:0] rom_size_q;
  map_req_t          req;
  logic              take;
  logic [DATA_W-1:0] ram_rdata;
  logic              rd_valid_q, rd_valid_d;
  logic              rd_range_q;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  logic              rd_move;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_size_q <= '0;
    end else if (cfg_we_i) begin
      rom_size_q <= cfg_wdata_i;
    end
  end

  // pipeline flow control
  assign rd_move    = rd_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !rd_valid_q || rd_move;
  assign take       = in_valid_i && in_ready_o;

  brm8k_map #(
    .ROM_BYTES (ROM_BYTES)
  ) u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .rom_size_i   (rom_size_q),
    .req_o        (req)
  );

  brm8k_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROM_BYTES)
  ) u_rom (
    .clk_i   (clk_i),
    .we_i    (req.ram_we),
    .waddr_i (req.addr[AW-1:0]),
    .wdata_i (write_data_i),
    .re_i    (req.ram_re),
    .raddr_i (req.addr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // read stage and output register valid bits
  always_comb begin
    rd_valid_d  = rd_valid_q;
    out_valid_d = out_valid_q;
    if (rd_move) begin
      rd_valid_d = 1'b0;
    end
    if (req.ram_re) begin
      rd_valid_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (rd_move) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: range flag rides with the store read, byte lands in the output register
  always_ff @(posedge clk_i) begin
    if (req.ram_re) begin
      rd_range_q <= req.in_range;
    end
    if (rd_move) begin
      out_data_q <= rd_range_q ? ram_rdata : OPEN_BUS;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule

>>> tb/sv/brm8k_read_check.sv
`timescale 1ns / 1ps
// transfer monitor for the banked 8 KiB ROM mapper: predicts each read byte and compares
// depends on brm8k_pkg; placed beside the block by tb, which only reads the counts

module brm8k_read_check #(
  parameter int unsigned ROM_BYTES = brm8k_pkg::ROM_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [brm8k_pkg::OP_W-1:0]   opcode_i,
  input  logic [brm8k_pkg::ADDR_W-1:0] address_i,
  input  logic [brm8k_pkg::DATA_W-1:0] write_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [brm8k_pkg::DATA_W-1:0] read_data_i,
  input  logic                         cfg_we_i,
  input  logic [brm8k_pkg::SIZE_W-1:0] cfg_wdata_i,
  output int                           mismatch_count_o,
  output int                           reads_pending_o
);

  import brm8k_pkg::*;

  // own copy of the mapper state
  logic [DATA_W-1:0] bank_sel [BANK_NUM];
  logic [DATA_W-1:0] rom_image [ROM_BYTES];
  logic [SIZE_W-1:0] rom_size;

  // bytes owed by bus reads, oldest first
  logic [DATA_W-1:0] read_bytes_q [$];
  logic [DATA_W-1:0] want_byte;
  logic [BUS_W-1:0]  bus_addr;
  int                mismatches = 0;
  int                pending = 0;

  assign mismatch_count_o = mismatches;
  assign reads_pending_o  = pending;

  // byte that a bus read returns with the current banks and size
  function automatic logic [DATA_W-1:0] mapped_byte(input logic [BUS_W-1:0] bus);
    logic [BUS_W-1:0] rel;
    logic [MAP_W-1:0] rom_addr;
    rel = bus - WIN_BASE;
    if (bus < WIN_BASE || bus >= WIN_END) begin
      rom_addr = MAP_W'(bus);
    end else begin
      rom_addr = {bank_sel[rel[OFF_W +: BANK_IW]], rel[OFF_W-1:0]};
    end
    if (rom_addr < rom_size && rom_addr < ROM_BYTES) begin
      return rom_image[rom_addr];
    end
    return OPEN_BUS;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BANK_NUM; i++) begin
        bank_sel[i] = DATA_W'(i);
      end
      rom_size = '0;
      read_bytes_q.delete();
      pending = 0;
    end else begin
      // result transfer against the oldest owed byte
      if (out_valid_i && out_ready_i) begin
        if (read_bytes_q.size() == 0) begin
          mismatches++;
          $error("read_data: expected no transfer, actual %02h", read_data_i);
        end else begin
          want_byte = read_bytes_q.pop_front();
          if (read_data_i !== want_byte) begin
            mismatches++;
            $error("read_data: expected %02h, actual %02h", want_byte, read_data_i);
          end
        end
      end

      // input transfer updates the state or owes a byte
      if (in_valid_i && in_ready_i) begin
        bus_addr = address_i[BUS_W-1:0];
        case (opcode_i)
          OP_LOAD: begin
            if (address_i < ROM_BYTES) rom_image[address_i] = write_data_i;
          end
          OP_READ: begin
            read_bytes_q.push_back(mapped_byte(bus_addr));
          end
          OP_WRITE: begin
            if (bus_addr >= REG_BASE && bus_addr < REG_END) begin
              bank_sel[bus_addr[OFF_W-1 -: BANK_IW]] = write_data_i;
            end
          end
          default: begin
          end
        endcase
      end

      if (cfg_we_i) rom_size = cfg_wdata_i;
      pending = read_bytes_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// stimulus and verdict for the banked 8 KiB ROM mapper: directed then random bus traffic
// depends on brm8k_pkg, banked_rom_mapper_8k_unit and brm8k_read_check

module tb;

  import brm8k_pkg::*;

  localparam int unsigned ROM_BYTES     = ROM_BYTES_DEF;
  localparam int unsigned STORE_BANKS   = ROM_BYTES >> OFF_W;
  localparam int unsigned HI_W          = ADDR_W - BUS_W;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 240;
  localparam int unsigned SETTLE_CYCLES = 4;

  // unused operation code, ignored by the block
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    GAP_NONE,
    GAP_SEND,
    GAP_RECV,
    GAP_BOTH
  } gap_mode_e;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   opcode = OP_LOAD;
  logic [ADDR_W-1:0] address = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] read_data;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  gap_mode_e         gap_mode = GAP_NONE;
  int                mismatch_count;
  int                reads_pending;
  int                items_sent = 0;
  int unsigned       cycle_count = 0;

  // stimulus-side view of the banks and of which ROM bytes hold data
  logic [DATA_W-1:0] bank_shadow [BANK_NUM];
  bit                rom_loaded [ROM_BYTES];

  banked_rom_mapper_8k_unit #(
    .ROM_BYTES(ROM_BYTES)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .address_i   (address),
    .write_data_i(write_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .read_data_o (read_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  brm8k_read_check #(
    .ROM_BYTES(ROM_BYTES)
  ) chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .address_i       (address),
    .write_data_i    (write_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .read_data_i     (read_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .mismatch_count_o(mismatch_count),
    .reads_pending_o (reads_pending)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[banked_rom_mapper_8k_unit] ERROR");
      $finish;
    end
  end

  function automatic int gap_pct();
    return (gap_mode == GAP_BOTH) ? 24 : 49;
  endfunction

  // result side stalls
  always @(negedge clk) begin
    if (gap_mode == GAP_RECV || gap_mode == GAP_BOTH) begin
      out_ready <= ($urandom_range(99) >= gap_pct());
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one input transfer, with optional idle cycles ahead of it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    while ((gap_mode == GAP_SEND || gap_mode == GAP_BOTH) &&
           $urandom_range(99) < gap_pct()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    address    <= addr;
    write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // ROM index that a bus read reaches with the current banks
  function automatic logic [MAP_W-1:0] rom_index(input logic [BUS_W-1:0] bus);
    logic [BUS_W-1:0] rel;
    rel = bus - WIN_BASE;
    if (bus < WIN_BASE || bus >= WIN_END) return MAP_W'(bus);
    return {bank_shadow[rel[OFF_W +: BANK_IW]], rel[OFF_W-1:0]};
  endfunction

  task automatic do_load(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    send_item(OP_LOAD, addr, data);
    rom_loaded[addr] = 1'b1;
  endtask

  // a read never reaches a byte that was not loaded: load it first
  task automatic do_read(input logic [ADDR_W-1:0] addr);
    logic [MAP_W-1:0] idx;
    idx = rom_index(addr[BUS_W-1:0]);
    if (idx < ROM_BYTES && !rom_loaded[idx]) do_load(ADDR_W'(idx), DATA_W'($urandom));
    send_item(OP_READ, addr, DATA_W'($urandom));
  endtask

  task automatic do_bank_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [BUS_W-1:0] bus;
    bus = addr[BUS_W-1:0];
    send_item(OP_WRITE, addr, data);
    if (bus >= REG_BASE && bus < REG_END) bank_shadow[bus[OFF_W-1 -: BANK_IW]] = data;
  endtask

  // mostly banks inside the store, sometimes any bank number
  function automatic logic [DATA_W-1:0] bank_number();
    if ($urandom_range(4) == 0) return DATA_W'($urandom);
    return DATA_W'($urandom_range(STORE_BANKS - 1));
  endfunction

  // wait until every read byte has come out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (reads_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rom_size(input logic [SIZE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one random item or a short bank switch followed by reads in that window
  task automatic random_item();
    int               kind;
    int               win;
    int               reads;
    logic [BUS_W-1:0] bus;
    kind = $urandom_range(99);
    if (kind < 40) begin
      if ($urandom_range(9) < 7) bus = BUS_W'($urandom_range(WIN_END - 1, WIN_BASE));
      else bus = BUS_W'($urandom);
      do_read({HI_W'($urandom), bus});
    end else if (kind < 55) begin
      if ($urandom_range(99) < 85) bus = REG_BASE + BUS_W'($urandom_range(16'h1FFF));
      else bus = BUS_W'($urandom);
      do_bank_write({HI_W'($urandom), bus}, bank_number());
    end else if (kind < 65) begin
      win   = $urandom_range(BANK_NUM - 1);
      bus   = REG_BASE + BUS_W'(win << (OFF_W - BANK_IW)) + BUS_W'($urandom_range(16'h7FF));
      do_bank_write({HI_W'($urandom), bus}, bank_number());
      reads = $urandom_range(4, 2);
      repeat (reads) begin
        bus = WIN_BASE + BUS_W'(win << OFF_W) + BUS_W'($urandom_range(16'h1FFF));
        do_read({HI_W'($urandom), bus});
      end
    end else if (kind < 92) begin
      do_load(ADDR_W'($urandom), DATA_W'($urandom));
    end else begin
      send_item(OP_UNUSED, ADDR_W'($urandom), DATA_W'($urandom));
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_size [PHASES];
    gap_mode_e         phase_gap  [4];
    int                target;

    phase_size = '{SIZE_W'(ROM_BYTES), '0, SIZE_W'(1), SIZE_W'(16'hC000),
                   SIZE_W'($urandom_range(ROM_BYTES)), SIZE_W'(ROM_BYTES)};
    phase_gap  = '{GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH};
    for (int i = 0; i < BANK_NUM; i++) begin
      bank_shadow[i] = DATA_W'(i);
    end

    // reset, then full ROM size
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_rom_size(SIZE_W'(ROM_BYTES));

    // directed: field extremes, every window, pass-through, banks 0 and beyond the store
    do_load('0, 8'h00);
    do_load('1, 8'hFF);
    do_load(18'h04000, 8'hA5);
    do_read(18'h00000);
    do_read(18'h03FFF);
    do_read(18'h04000);
    do_read(18'h3BFFF);
    do_read(18'h0C000);
    do_read(18'h3FFFF);
    do_bank_write(18'h06000, DATA_W'(STORE_BANKS - 1));
    do_read(18'h04123);
    do_bank_write(18'h36800, 8'hFF);
    do_read(18'h06000);
    do_bank_write(18'h07000, DATA_W'(STORE_BANKS));
    do_read(18'h08000);
    do_bank_write(18'h07FFF, 8'h00);
    do_read(18'h0BFFF);
    do_bank_write(18'h05FFF, 8'h07);
    do_bank_write(18'h08000, 8'h07);
    do_read(18'h04000);
    send_item(OP_UNUSED, '1, '1);
    do_read(18'h05FFF);

    // random phases, each with its own ROM size and idle pattern
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_rom_size(phase_size[p]);
      gap_mode <= phase_gap[p % 4];
      target = items_sent + PHASE_ITEMS / 2;
      while (items_sent < target) random_item();
      // in phase 1 the sender holds off until every read byte has come out
      if (p == 1) drain();
      target = items_sent + PHASE_ITEMS / 2;
      while (items_sent < target) random_item();
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && reads_pending == 0) begin
      $display("[banked_rom_mapper_8k_unit] OK");
    end else begin
      $display("[banked_rom_mapper_8k_unit] ERROR");
    end
    $finish;
  end

endmodule
